[rtl/mhp_pkg.sv]
// ----------------------------------------------------------------------------
// mhp_pkg
// Shared constants, types and helpers of the murmur3 hash partitioner.
// ----------------------------------------------------------------------------
package mhp_pkg;

	// partition count, a power of two from 2 to 8
	localparam int PARTITIONS = 8;
	localparam logic [2:0] PART_MASK = 3'((PARTITIONS - 1) & 7);

	localparam logic [31:0] SEED_RESET = 32'd42;

	// murmur3 x86_32 constants
	localparam logic [31:0] MM_C1 = 32'hCC9E2D51;
	localparam logic [31:0] MM_C2 = 32'h1B873593;
	localparam logic [31:0] MM_N  = 32'hE6546B64;
	localparam logic [31:0] MM_F1 = 32'h85EBCA6B;
	localparam logic [31:0] MM_F2 = 32'hC2B2AE35;

	// job queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// register map
	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_SEED = PADDR_W'(0);

	// one unit of work for the back part
	typedef struct packed {
		logic        is_final;
		logic        do_mix;
		logic        first;
		logic [31:0] seed;
		logic [31:0] blk;
		logic [7:0]  klen;
		logic        key_ok;
	} mhp_job_t;

	typedef struct packed {
		logic        wr;
		logic [31:0] data;
	} mhp_cfg_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

endpackage

[rtl/mhp_queue.sv]
// ----------------------------------------------------------------------------
// mhp_queue
// Small job queue that lets the byte front end and the mixing back end stall
// independently.
// ----------------------------------------------------------------------------
module mhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mhp_pkg::mhp_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output mhp_pkg::mhp_job_t head_job
);

	mhp_pkg::mhp_job_t                entry_q [mhp_pkg::QDEPTH];
	logic [mhp_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [mhp_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [mhp_pkg::QCNT_W-1:0]       count_q;
	logic                             do_push;
	logic                             do_pop;

	assign full       = (count_q == mhp_pkg::QCNT_W'(mhp_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == mhp_pkg::QPTR_W'(mhp_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == mhp_pkg::QPTR_W'(mhp_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/mhp_front.sv]
// ----------------------------------------------------------------------------
// mhp_front
// Byte intake: tracks tuple position, picks out key bytes, packs them into
// 32-bit blocks and issues mix and finalize jobs.
// ----------------------------------------------------------------------------
module mhp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic [7:0]        key_start,
	input  logic [7:0]        key_len,
	input  logic              last_byte,
	input  mhp_pkg::mhp_cfg_t cfg,
	input  logic [31:0]       seed,
	output logic              job_valid,
	output mhp_pkg::mhp_job_t job,
	input  logic              job_full
);

	logic [7:0]  pos_q;
	logic        overlong_q;
	logic [31:0] blk_q;
	logic [1:0]  cnt_q;
	logic        first_q;
	logic [31:0] tuple_seed_q;

	logic        accept;
	logic [8:0]  key_end;
	logic        in_key;
	logic [31:0] shifted;
	logic [31:0] blk_new;
	logic [1:0]  cnt_new;
	logic        blk_done;
	logic [8:0]  seen_len;
	logic        key_ok;

	assign in_stall  = job_full;
	assign accept    = in_valid && !job_full;

	assign key_end   = {1'b0, key_start} + {1'b0, key_len};
	assign in_key    = !overlong_q && (pos_q >= key_start) && ({1'b0, pos_q} < key_end);
	assign shifted   = {24'b0, data_byte} << {cnt_q, 3'b000};
	assign blk_new   = in_key ? (blk_q | shifted) : blk_q;
	assign cnt_new   = in_key ? cnt_q + 2'd1 : cnt_q;
	assign blk_done  = in_key && (cnt_q == 2'd3);
	assign seen_len  = overlong_q ? 9'd257 : {1'b0, pos_q} + 9'd1;
	assign key_ok    = (seen_len <= 9'd255) && (key_end <= seen_len);

	assign job_valid = accept && (last_byte || blk_done);

	always_comb begin
		job.is_final = last_byte;
		job.do_mix   = blk_done || (cnt_new != 2'd0);
		job.first    = first_q;
		job.seed     = tuple_seed_q;
		job.blk      = blk_new;
		job.klen     = key_len;
		job.key_ok   = key_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			overlong_q   <= 1'b0;
			blk_q        <= '0;
			cnt_q        <= '0;
			first_q      <= 1'b1;
			tuple_seed_q <= mhp_pkg::SEED_RESET;
		end else if (accept) begin
			if (last_byte) begin
				pos_q        <= '0;
				overlong_q   <= 1'b0;
				blk_q        <= '0;
				cnt_q        <= '0;
				first_q      <= 1'b1;
				tuple_seed_q <= cfg.wr ? cfg.data : seed;
			end else begin
				if (pos_q == 8'd255) begin
					overlong_q <= 1'b1;
				end else if (!overlong_q) begin
					pos_q <= pos_q + 8'd1;
				end
				blk_q <= blk_done ? '0 : blk_new;
				cnt_q <= cnt_new;
				if (blk_done) begin
					first_q <= 1'b0;
				end
			end
		end else if (cfg.wr && (pos_q == 8'd0) && !overlong_q) begin
			// seed change before any byte of the tuple applies to this tuple
			tuple_seed_q <= cfg.data;
		end
	end

endmodule

[rtl/mhp_back.sv]
// ----------------------------------------------------------------------------
// mhp_back
// Mixing engine: runs block mixes and the finalizer on a shared datapath,
// one constant multiply per cycle, and holds the result for the output side.
// ----------------------------------------------------------------------------
module mhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  mhp_pkg::mhp_job_t job,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       hash_value,
	output logic [2:0]        partition,
	output logic              key_valid
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_K2   = 3'd1;
	localparam logic [2:0] ST_HM   = 3'd2;
	localparam logic [2:0] ST_F1   = 3'd3;
	localparam logic [2:0] ST_F2   = 3'd4;
	localparam logic [2:0] ST_F3   = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic        final_q;
	logic [7:0]  klen_q;
	logic        ok_q;
	logic        out_valid_q;
	logic [31:0] hash_q;
	logic [2:0]  part_q;
	logic        kv_q;

	logic [31:0] h_base;
	logic [31:0] h_rot;
	logic [31:0] h_mix;
	logic [31:0] h_fin;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign job_pop  = (state_q == ST_IDLE) && job_valid;
	assign h_base   = job.first ? job.seed : h_q;
	assign h_rot    = mhp_pkg::rotl(h_q ^ k_q, 13);
	// h * 5 + n as shift and add
	assign h_mix    = h_rot + (h_rot << 2) + mhp_pkg::MM_N;
	assign h_fin    = h_q ^ (h_q >> 16);

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;
	assign partition  = part_q;
	assign key_valid  = kv_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					final_q <= job.is_final;
					klen_q  <= job.klen;
					ok_q    <= job.key_ok;
					if (job.do_mix) begin
						h_q <= h_base;
						k_q <= job.blk * mhp_pkg::MM_C1;
					end else begin
						h_q <= h_base ^ {24'b0, job.klen};
					end
				end
			end
			ST_K2: begin
				k_q <= mhp_pkg::rotl(k_q, 15) * mhp_pkg::MM_C2;
			end
			ST_HM: begin
				h_q <= final_q ? (h_mix ^ {24'b0, klen_q}) : h_mix;
			end
			ST_F1: begin
				h_q <= h_fin * mhp_pkg::MM_F1;
			end
			ST_F2: begin
				h_q <= (h_q ^ (h_q >> 13)) * mhp_pkg::MM_F2;
			end
			ST_F3: begin
				if (out_free) begin
					hash_q <= ok_q ? h_fin : '0;
					part_q <= ok_q ? (h_fin[2:0] & mhp_pkg::PART_MASK) : '0;
					kv_q   <= ok_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_F3) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= job.do_mix ? ST_K2 : ST_F1;
					end
				end
				ST_K2: begin
					state_q <= ST_HM;
				end
				ST_HM: begin
					state_q <= final_q ? ST_F1 : ST_IDLE;
				end
				ST_F1: begin
					state_q <= ST_F2;
				end
				ST_F2: begin
					state_q <= ST_F3;
				end
				ST_F3: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/murmur3_hash_partitioner_top.sv]
// ----------------------------------------------------------------------------
// murmur3_hash_partitioner_top
// MurmurHash3 x86_32 key hasher and partition selector over a byte stream.
// ----------------------------------------------------------------------------
// Tuple bytes enter one per cycle on the input channel while in_stall is low;
// the front end packs key bytes into 32-bit blocks and hands each full block,
// and the tuple end, to a two-entry job queue. The back end mixes a block in
// its idle, K2 and HM states and finishes a tuple with an optional tail mix,
// two finalizer multiplies and a result load, one 32x32 constant multiply per
// cycle. A key streams at one byte per cycle while the queue is not full; the
// back end takes a new job only when idle, so it sets the rate for a run of
// very short tuples. hash_seed sits at address 0 and resets to 42.
module murmur3_hash_partitioner_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	input  logic [7:0]                   key_start,
	input  logic [7:0]                   key_len,
	input  logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  hash_value,
	output logic [2:0]                   partition,
	output logic                         key_valid,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mhp_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [31:0]       seed_q;
	mhp_pkg::mhp_cfg_t cfg;
	logic              push;
	mhp_pkg::mhp_job_t push_job;
	logic              q_full;
	logic              pop;
	logic              head_valid;
	mhp_pkg::mhp_job_t head_job;

	assign pready   = 1'b1;
	assign cfg.wr   = psel && penable && pwrite && (paddr == mhp_pkg::ADDR_SEED);
	assign cfg.data = pwdata;
	assign prdata   = (paddr == mhp_pkg::ADDR_SEED) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= mhp_pkg::SEED_RESET;
		end else if (cfg.wr) begin
			seed_q <= cfg.data;
		end
	end

	mhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.key_start  (key_start),
		.key_len    (key_len),
		.last_byte  (last_byte),
		.cfg        (cfg),
		.seed       (seed_q),
		.job_valid  (push),
		.job        (push_job),
		.job_full   (q_full)
	);

	mhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	mhp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (head_valid),
		.job        (head_job),
		.job_pop    (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.partition  (partition),
		.key_valid  (key_valid)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the murmur3 hash partitioner.
// ----------------------------------------------------------------------------
// Tuples are queued byte by byte and driven on the input channel; every
// accepted byte goes through a local murmur3 x86_32 predictor, and each
// result on the output channel is checked against the oldest prediction.
// The run covers directed corner tuples, then random tuples under several
// seeds and idle/stall mixes, including one long output hold.
module tb;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] off;
		logic [7:0] klen;
		logic       last;
	} tuple_byte_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [2:0]  part;
		logic        ok;
	} hash_result_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [7:0]                  data_byte = '0;
	logic [7:0]                  key_start = '0;
	logic [7:0]                  key_len = '0;
	logic                        last_byte = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [31:0]                 hash_value;
	logic [2:0]                  partition;
	logic                        key_valid;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [mhp_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;

	murmur3_hash_partitioner_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.key_start  (key_start),
		.key_len    (key_len),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.partition  (partition),
		.key_valid  (key_valid),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	tuple_byte_t  tuple_bytes_q[$];
	hash_result_t hash_due_q[$];

	logic in_taken = 1'b0;
	logic long_hold = 1'b0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   phase_no = -1;
	int   queued_bytes = 0;
	int   bytes_taken = 0;
	int   hashes_seen = 0;
	int   rejects_seen = 0;
	int   bad_count = 0;

	// predictor state
	logic [31:0] seed_reg = mhp_pkg::SEED_RESET;
	logic [31:0] run_hash = mhp_pkg::SEED_RESET;
	logic [31:0] pend_blk = '0;
	logic [1:0]  pend_cnt = '0;
	logic [7:0]  byte_pos = '0;
	logic        overlong = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [31:0] blk_mix(input logic [31:0] h, input logic [31:0] k);
		k = k * mhp_pkg::MM_C1;
		k = rol32(k, 15);
		k = k * mhp_pkg::MM_C2;
		h = rol32(h ^ k, 13);
		return h * 32'd5 + mhp_pkg::MM_N;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		h = h ^ (h >> 16);
		h = h * mhp_pkg::MM_F1;
		h = h ^ (h >> 13);
		h = h * mhp_pkg::MM_F2;
		return h ^ (h >> 16);
	endfunction

	// absorbs one tuple byte; done is set on the final byte with its result
	function automatic hash_result_t murmur_absorb(input tuple_byte_t b, output bit done);
		int pos_i;
		int tlen;
		logic [31:0] h;
		hash_result_t r;
		done = 1'b0;
		r = '0;
		pos_i = int'(byte_pos);
		if (!overlong && pos_i >= int'(b.off) && pos_i < int'(b.off) + int'(b.klen)) begin
			pend_blk = pend_blk | (32'(b.data) << (8 * pend_cnt));
			pend_cnt = pend_cnt + 2'd1;
			if (pend_cnt == 2'd0) begin
				run_hash = blk_mix(run_hash, pend_blk);
				pend_blk = '0;
			end
		end
		tlen = overlong ? 257 : pos_i + 1;
		if (!b.last) begin
			if (pos_i == 255)
				overlong = 1'b1;
			else if (!overlong)
				byte_pos = byte_pos + 8'd1;
			return r;
		end
		h = run_hash;
		if (pend_cnt != 2'd0)
			h = blk_mix(h, pend_blk);
		h = avalanche(h ^ 32'(b.klen));
		done = 1'b1;
		if (tlen <= 255 && int'(b.off) + int'(b.klen) <= tlen)
			r = '{h, 3'(h & 32'(mhp_pkg::PARTITIONS - 1)), 1'b1};
		byte_pos = '0;
		run_hash = seed_reg;
		pend_blk = '0;
		pend_cnt = '0;
		overlong = 1'b0;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		bad_count++;
		if (bad_count <= 10)
			$display("%0t ERROR %s", $time, msg);
	endtask

	// request driver: holds a stalled request, else sends or idles
	always @(negedge clk) begin : drive_req
		tuple_byte_t nxt;
		if (!(in_valid && !in_taken)) begin
			if (arst_n && tuple_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = tuple_bytes_q.pop_front();
				data_byte  <= nxt.data;
				key_start  <= nxt.off;
				key_len    <= nxt.klen;
				last_byte  <= nxt.last;
				in_valid   <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		out_stall <= long_hold || ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin : watch
		hash_result_t exp_r;
		hash_result_t got_r;
		bit done;
		in_taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			bytes_taken++;
			exp_r = murmur_absorb({data_byte, key_start, key_len, last_byte}, done);
			if (done)
				hash_due_q.push_back(exp_r);
		end
		if (arst_n && out_valid && !out_stall) begin
			hashes_seen++;
			got_r = {hash_value, partition, key_valid};
			if (!key_valid)
				rejects_seen++;
			if (hash_due_q.size() == 0) begin
				flag_error($sformatf("unexpected result hash=%h part=%0d ok=%b",
					hash_value, partition, key_valid));
			end else begin
				exp_r = hash_due_q.pop_front();
				if (got_r.hash !== exp_r.hash || got_r.part !== exp_r.part
						|| got_r.ok !== exp_r.ok)
					flag_error($sformatf("exp hash=%h part=%0d ok=%b, got hash=%h part=%0d ok=%b",
						exp_r.hash, exp_r.part, exp_r.ok, got_r.hash, got_r.part, got_r.ok));
			end
		end
	end

	// long output hold while the sender keeps pushing, to back up the pipe
	initial begin
		wait (phase_no == 0);
		repeat (30) @(negedge clk);
		long_hold <= 1'b1;
		repeat (400) @(negedge clk);
		long_hold <= 1'b0;
	end

	task automatic apb_cycle(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= mhp_pkg::ADDR_SEED;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_seed_readback();
		logic [31:0] rd;
		apb_cycle(1'b0, '0, rd);
		if (rd !== seed_reg)
			flag_error($sformatf("hash_seed read exp %h got %h", seed_reg, rd));
	endtask

	task automatic set_seed(input logic [31:0] val);
		logic [31:0] rd;
		apb_cycle(1'b1, val, rd);
		seed_reg = val;
		if (byte_pos == 0 && !overlong)
			run_hash = val;
		check_seed_readback();
	endtask

	// drift: geometry may change on any byte of the tuple
	task automatic queue_tuple(input int len, input int off, input int klen,
			input bit drift, input bit stripes);
		tuple_byte_t b;
		for (int i = 0; i < len; i++) begin
			b.data = stripes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
			b.off  = (drift && $urandom_range(3) == 0) ? 8'($urandom) : 8'(off);
			b.klen = (drift && $urandom_range(3) == 0) ? 8'($urandom) : 8'(klen);
			b.last = (i == len - 1);
			tuple_bytes_q.push_back(b);
			queued_bytes++;
		end
	endtask

	task automatic queue_random_tuple();
		int pick;
		int len;
		int off;
		int klen;
		pick = $urandom_range(99);
		len = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
		if (pick < 72) begin
			off = ($urandom_range(1) == 0) ? 0 : $urandom_range(0, len);
			klen = $urandom_range(0, len - off);
			queue_tuple(len, off, klen, 1'b0, 1'b0);
		end else if (pick < 84) begin
			// key runs past the tuple end
			do begin
				off = $urandom_range(255);
				klen = $urandom_range(255);
			end while (off + klen <= len);
			queue_tuple(len, off, klen, 1'b0, 1'b0);
		end else if (pick < 92) begin
			queue_tuple(len, $urandom_range(0, len + 3), 0, 1'b0, 1'b0);
		end else begin
			queue_tuple(len, $urandom_range(0, len), $urandom_range(0, len), 1'b1, 1'b0);
		end
	endtask

	task automatic drain();
		while (tuple_bytes_q.size() != 0 || in_valid || hash_due_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		int mark;
		wait (arst_n === 1'b1);
		@(negedge clk);
		check_seed_readback();

		// directed corners under the reset seed
		queue_tuple(1, 0, 0, 1'b0, 1'b1);      // empty key
		queue_tuple(4, 0, 4, 1'b0, 1'b1);      // one full block
		queue_tuple(3, 0, 3, 1'b0, 1'b0);      // three-byte tail
		queue_tuple(4, 1, 2, 1'b0, 1'b0);      // two-byte tail, offset key
		queue_tuple(2, 1, 1, 1'b0, 1'b1);      // one-byte tail
		queue_tuple(2, 1, 2, 1'b0, 1'b0);      // key one past the end
		queue_tuple(1, 255, 255, 1'b0, 1'b1);  // key far out of range
		queue_tuple(5, 1, 3, 1'b1, 1'b0);      // geometry changes mid-tuple
		queue_tuple(3, 3, 0, 1'b0, 1'b0);      // empty key right at the end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					set_seed(32'h0000_0000);
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					set_seed(32'hFFFF_FFFF);
					send_idle_pct = 60;
					stall_pct = 0;
				end
				2: begin
					set_seed($urandom);
					send_idle_pct = 0;
					stall_pct = 60;
				end
				default: begin
					set_seed($urandom);
					send_idle_pct = 31;
					stall_pct = 31;
				end
			endcase
			mark = queued_bytes;
			if (ph == 3) begin
				queue_tuple(255, 0, 255, 1'b0, 1'b0);  // longest valid key
				queue_tuple(257, 3, 10, 1'b0, 1'b0);   // tuple runs past 255 bytes
			end
			while (queued_bytes - mark < 250)
				queue_random_tuple();
			phase_no = ph;
			drain();
		end

		$display("checked %0d results (%0d rejected keys) from %0d tuple bytes",
			hashes_seen, rejects_seen, bytes_taken);
		$display("seeds: reset, zero, all ones, random; idle/stall mixes and a 400-cycle hold");
		if (bad_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", bad_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
